>>> src/kcs_pkg.sv
// Package for the keyword content scanner: transaction types, register
// indexes, verdict codes, keyword tables and the tail compare function.
// No dependencies.
package kcs_pkg;

	// Longest keyword in bytes; the compare window covers this many bytes.
	localparam int unsigned KW_MAX_LEN = 15;
	localparam int unsigned KW_NUM = 6;
	localparam int unsigned HALF_NUM = 4;
	localparam int unsigned WIN_W = 8 * KW_MAX_LEN;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic       blocked;
		logic [3:0] block_reason;
	} result_t;

	typedef logic [1:0] cfg_index_t;
	typedef logic [5:0] cfg_data_t;

	localparam cfg_index_t CFG_PAIR_RULE_ENABLE = 2'd0;
	localparam cfg_index_t CFG_KEYWORD_MASK     = 2'd1;

	localparam logic [3:0] REASON_NONE      = 4'd0;
	localparam logic [3:0] REASON_PAIR_FIRST  = 4'd7;
	localparam logic [3:0] REASON_PAIR_SECOND = 4'd8;

	// Keyword text, right-justified so that byte k counted back from the
	// last character sits at bits [8k +: 8]. Unused upper bytes are zero.
	localparam logic [WIN_W-1:0] KW_TEXT [KW_NUM] = '{
		WIN_W'({"sponge", "bob"}),
		WIN_W'({"britney", " spears"}),
		WIN_W'({"paris", " hilton"}),
		WIN_W'({"norrk", "\303\266", "ping"}),
		WIN_W'("norrkoping"),
		WIN_W'("norrk&ouml;ping")
	};
	localparam logic [3:0] KW_LEN [KW_NUM] = '{4'd9, 4'd14, 4'd12, 4'd11, 4'd10, 4'd15};

	localparam logic [WIN_W-1:0] HALF_TEXT [HALF_NUM] = '{
		WIN_W'("paris"),
		WIN_W'("hilton"),
		WIN_W'("britney"),
		WIN_W'("spears")
	};
	localparam logic [3:0] HALF_LEN [HALF_NUM] = '{4'd5, 4'd6, 4'd7, 4'd6};

	// True when the window ends with the low len bytes of text; false when len is zero.
	function automatic logic tail_match(input logic [WIN_W-1:0] text,
			input logic [3:0] len, input logic [WIN_W-1:0] win);
		logic hit;
		hit = (len != 4'd0);
		for (int k = 0; k < KW_MAX_LEN; k++) begin
			if (4'(k) < len && text[8*k +: 8] != win[8*k +: 8]) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

>>> src/keyword_content_scanner.sv
// Keyword content scanner top level; depends on kcs_pkg.
// The verdict is in the output register in the cycle after the last byte is taken.
// Throughput: one byte per cycle; input stalls only while a verdict waits to be taken.
// Reset (arst_n low, asynchronous): registers return to pair rule on, all keywords
// enabled, empty history and clear flags; no result is pending.
module keyword_content_scanner #(
	parameter int unsigned WINDOW_BYTES  = 15,
	parameter int unsigned KEYWORD_COUNT = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  kcs_pkg::item_t     in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output kcs_pkg::result_t   out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  kcs_pkg::cfg_index_t cfg_index,
	input  kcs_pkg::cfg_data_t  cfg_data
);
	import kcs_pkg::*;

	localparam int unsigned HIST_LEN = WINDOW_BYTES - 1;
	localparam logic [5:0] KW_LIVE = 6'((7'd1 << KEYWORD_COUNT) - 7'd1);

	logic        pair_en_q;
	logic [5:0]  kw_mask_q;
	logic [7:0]  hist_q [HIST_LEN];
	logic [5:0]  kw_seen_q;
	logic [3:0]  half_seen_q;
	logic        text_ended_q;
	logic        out_valid_q;
	result_t     out_data_q;

	logic        accept;
	logic        scan;
	logic [7:0]  folded;
	logic [WIN_W-1:0] win;
	logic [5:0]  kw_hit;
	logic [3:0]  half_hit;
	logic [5:0]  kw_all;
	logic [3:0]  half_all;
	logic [5:0]  kw_final;
	logic [3:0]  reason;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		folded = in_data.data_byte;
		if (in_data.data_byte inside {[8'h41:8'h5A]}) begin
			folded = in_data.data_byte + 8'd32;
		end
	end

	assign scan = accept && !text_ended_q && (in_data.data_byte != 8'd0);

	// Window with the current byte at the bottom and older bytes above it.
	always_comb begin
		win[7:0] = folded;
		for (int k = 1; k < KW_MAX_LEN; k++) begin
			win[8*k +: 8] = hist_q[k-1];
		end
	end

	always_comb begin
		for (int i = 0; i < KW_NUM; i++) begin
			kw_hit[i] = KW_LIVE[i] && tail_match(KW_TEXT[i], KW_LEN[i], win);
		end
		for (int i = 0; i < HALF_NUM; i++) begin
			half_hit[i] = tail_match(HALF_TEXT[i], HALF_LEN[i], win);
		end
	end

	assign kw_all   = scan ? (kw_seen_q | kw_hit) : kw_seen_q;
	assign half_all = scan ? (half_seen_q | half_hit) : half_seen_q;
	assign kw_final = kw_all & kw_mask_q;

	// The lowest enabled keyword wins; the pair rules only apply when none is found.
	always_comb begin
		reason = REASON_NONE;
		if (pair_en_q && half_all[1:0] == 2'b11) begin
			reason = REASON_PAIR_FIRST;
		end else if (pair_en_q && half_all[3:2] == 2'b11) begin
			reason = REASON_PAIR_SECOND;
		end
		for (int i = KW_NUM - 1; i >= 0; i--) begin
			if (kw_final[i]) begin
				reason = 4'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_en_q <= 1'b1;
			kw_mask_q <= 6'h3F;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PAIR_RULE_ENABLE: pair_en_q <= cfg_data[0];
				CFG_KEYWORD_MASK:     kw_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST_LEN; k++) begin
				hist_q[k] <= 8'd0;
			end
			kw_seen_q    <= '0;
			half_seen_q  <= '0;
			text_ended_q <= 1'b0;
		end else if (accept && in_data.last_byte) begin
			for (int k = 0; k < HIST_LEN; k++) begin
				hist_q[k] <= 8'd0;
			end
			kw_seen_q    <= '0;
			half_seen_q  <= '0;
			text_ended_q <= 1'b0;
		end else if (accept) begin
			if (scan) begin
				hist_q[0] <= folded;
				for (int k = 1; k < HIST_LEN; k++) begin
					hist_q[k] <= hist_q[k-1];
				end
			end
			kw_seen_q   <= kw_all;
			half_seen_q <= half_all;
			if (!text_ended_q && in_data.data_byte == 8'd0) begin
				text_ended_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && in_data.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.last_byte) begin
			out_data_q.blocked      <= (reason != REASON_NONE);
			out_data_q.block_reason <= reason;
		end
	end

`ifndef NO_ASSERTIONS
	a_verdict_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.last_byte) |=> out_valid)
		else $error("verdict missing after last byte");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.last_byte) |=>
		(kw_seen_q == 6'd0 && half_seen_q == 4'd0 && !text_ended_q))
		else $error("message state not cleared after last byte");

	a_blocked_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.blocked == (out_data.block_reason != REASON_NONE)))
		else $error("blocked flag disagrees with reason");

	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.block_reason <= REASON_PAIR_SECOND))
		else $error("reason code out of range");

	a_only_live_keywords: assert property (@(posedge clk) disable iff (!arst_n)
		(kw_seen_q & ~KW_LIVE) == 6'd0)
		else $error("flag set for keyword beyond count");
`endif

endmodule

>>> verif/keyword_content_scanner_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the keyword content scanner. It follows the config, byte and verdict
// transactions, predicts every verdict and compares it with the DUT. Depends on kcs_pkg.
module keyword_content_scanner_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  kcs_pkg::item_t      in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  kcs_pkg::result_t    out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  kcs_pkg::cfg_index_t cfg_index,
	input  kcs_pkg::cfg_data_t  cfg_data,
	output int                  fail_count,
	output int                  verdicts_pending
);
	import kcs_pkg::*;

	localparam int HIST_DEPTH = 14;

	logic [7:0] history [HIST_DEPTH];
	logic [5:0] keyword_flags;
	logic [3:0] half_flags;
	logic       text_done;
	logic       pair_on;
	logic [5:0] keyword_mask;
	result_t    verdict_q [$];
	int         errors = 0;

	function automatic string keyword_str(input int idx);
		case (idx)
			0: return {"sponge", "bob"};
			1: return {"britney", " spears"};
			2: return {"paris", " hilton"};
			3: return {"norrk", "\303\266", "ping"};
			4: return "norrkoping";
			default: return "norrk&ouml;ping";
		endcase
	endfunction

	function automatic string half_str(input int idx);
		case (idx)
			0: return "paris";
			1: return "hilton";
			2: return "britney";
			default: return "spears";
		endcase
	endfunction

	// The current byte plus the history form the window; the word must end at the current byte.
	function automatic logic ends_with(input string w, input logic [7:0] cur);
		int n;
		logic [7:0] ch;
		n = w.len();
		ch = w[n-1];
		if (ch != cur)
			return 1'b0;
		for (int k = 1; k < n; k++) begin
			ch = w[n-1-k];
			if (ch != history[k-1])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void clear_message();
		for (int k = 0; k < HIST_DEPTH; k++)
			history[k] = 8'h00;
		keyword_flags = '0;
		half_flags = '0;
		text_done = 1'b0;
	endfunction

	function automatic void take_byte(input item_t it);
		logic [7:0] b;
		logic [5:0] hits;
		result_t    r;
		b = it.data_byte;
		if (!text_done) begin
			if (b == 8'h00) begin
				text_done = 1'b1;
			end else begin
				if (b >= "A" && b <= "Z")
					b = b + 8'd32;
				for (int i = 0; i < 6; i++)
					if (ends_with(keyword_str(i), b))
						keyword_flags[i] = 1'b1;
				for (int i = 0; i < 4; i++)
					if (ends_with(half_str(i), b))
						half_flags[i] = 1'b1;
				for (int k = HIST_DEPTH - 1; k > 0; k--)
					history[k] = history[k-1];
				history[0] = b;
			end
		end
		if (it.last_byte) begin
			r.block_reason = REASON_NONE;
			hits = keyword_flags & keyword_mask;
			// Walk down so that the lowest enabled keyword is left standing.
			for (int i = 5; i >= 0; i--)
				if (hits[i])
					r.block_reason = 4'(i + 1);
			if (r.block_reason == REASON_NONE && pair_on) begin
				if (half_flags[1:0] == 2'b11)
					r.block_reason = REASON_PAIR_FIRST;
				else if (half_flags[3:2] == 2'b11)
					r.block_reason = REASON_PAIR_SECOND;
			end
			r.blocked = (r.block_reason != REASON_NONE);
			verdict_q = {verdict_q, r};
			clear_message();
		end
	endfunction

	function automatic void note_mismatch(input string what);
		errors++;
		if (errors <= 10)
			$display("%0t: mismatch: %s", $realtime, what);
	endfunction

	function automatic void check_verdict();
		result_t exp_r;
		if (verdict_q.size() == 0) begin
			note_mismatch($sformatf("verdict with none predicted: blocked=%0d reason=%0d",
				out_data.blocked, out_data.block_reason));
		end else begin
			exp_r = verdict_q.pop_front();
			if (out_data.blocked !== exp_r.blocked || out_data.block_reason !== exp_r.block_reason)
				note_mismatch($sformatf("expected blocked=%0d reason=%0d, got blocked=%0d reason=%0d",
					exp_r.blocked, exp_r.block_reason, out_data.blocked, out_data.block_reason));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_on = 1'b1;
			keyword_mask = '1;
			clear_message();
			verdict_q.delete();
			verdicts_pending <= 0;
			fail_count <= errors;
		end else begin
			if (out_valid && !out_stall)
				check_verdict();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PAIR_RULE_ENABLE: pair_on = cfg_data[0];
					CFG_KEYWORD_MASK: keyword_mask = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				take_byte(in_data);
			verdicts_pending <= verdict_q.size();
			fail_count <= errors;
		end
	end

endmodule

>>> verif/keyword_content_scanner_tb.sv
`timescale 1ns / 100ps
// Top of the keyword content scanner testbench: clock, reset, message and config stimulus,
// random stalls and the verdict. Depends on kcs_pkg, the DUT and the scoreboard module.
module keyword_content_scanner_tb;
	import kcs_pkg::*;

	localparam int STALL_PCT      = 7;
	localparam int ITEM_TARGET    = 1850;
	localparam int PHASES         = 8;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	// Indexes that map to no register; writes to them must be dropped.
	localparam cfg_index_t CFG_SPARE_LO = 2'd2;
	localparam cfg_index_t CFG_SPARE_HI = 2'd3;

	typedef logic [7:0] text_q_t [$];

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	item_t      in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	result_t    out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_index_t cfg_index = '0;
	cfg_data_t  cfg_data = '0;
	logic       idle_en = 1'b0;
	int         fail_count;
	int         verdicts_pending;
	int         bytes_sent = 0;
	int         quiet_cycles = 0;

	always #5 clk = ~clk;

	keyword_content_scanner DUT (.*);

	keyword_content_scanner_checker u_scoreboard (.*);

	always @(posedge clk)
		out_stall <= idle_en && ($urandom_range(99) < STALL_PCT);

	// Reset or any accepted transaction on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic string stim_word(input int idx);
		case (idx)
			0: return {"sponge", "bob"};
			1: return {"britney", " spears"};
			2: return {"paris", " hilton"};
			3: return {"norrk", "\303\266", "ping"};
			4: return "norrkoping";
			5: return "norrk&ouml;ping";
			6: return "paris";
			7: return "hilton";
			8: return "britney";
			default: return "spears";
		endcase
	endfunction

	// Mostly words and name halves in random case, some of them damaged, plus pure noise.
	function automatic text_q_t make_message();
		text_q_t    m;
		int         target;
		int         pick;
		int         cut;
		string      w;
		logic [7:0] ch;
		if ($urandom_range(99) < 25) begin
			target = $urandom_range(1, 30);
			repeat (target)
				m = {m, 8'($urandom_range(255))};
		end else begin
			target = $urandom_range(6, 40);
			while (m.size() < target) begin
				pick = $urandom_range(15);
				if (pick <= 9) begin
					w = stim_word(pick);
					cut = ($urandom_range(99) < 20) ? $urandom_range(w.len() - 1) : -1;
					for (int i = 0; i < w.len(); i++) begin
						ch = w[i];
						if (i == cut)
							ch = 8'($urandom_range("z", "a"));
						if (ch >= "a" && ch <= "z" && $urandom_range(99) < 30)
							ch = ch - 8'd32;
						m = {m, ch};
					end
				end else if (pick <= 12) begin
					m = {m, 8'h20};
				end else if (pick <= 14) begin
					m = {m, 8'($urandom_range("z", "a"))};
				end else begin
					m = {m, 8'($urandom_range(255))};
				end
			end
			if ($urandom_range(99) < 8)
				m[$urandom_range(m.size() - 1)] = 8'h00;
		end
		return m;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic lst);
		while (idle_en && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= '{data_byte: b, last_byte: lst};
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_message(input text_q_t msg);
		foreach (msg[i])
			push_byte(msg[i], i == msg.size() - 1);
	endtask

	task automatic send_text(input string s);
		text_q_t m;
		for (int i = 0; i < s.len(); i++)
			m = {m, 8'(s[i])};
		send_message(m);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic reconfigure(input logic pair, input cfg_data_t mask);
		wait_drained();
		// Upper data bits of the pair register are don't-care; keep them random.
		write_reg(CFG_PAIR_RULE_ENABLE, {5'($urandom_range(31)), pair});
		write_reg(CFG_KEYWORD_MASK, mask);
		if ($urandom_range(1))
			write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
				6'($urandom_range(63)));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset settings: byte extremes, raw high bytes,
		// mixed case, and text after a zero byte that must not be scanned.
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		send_text({"NoRRK", "\303\266", "PING"});
		push_byte("Z", 1'b0);
		push_byte(8'h00, 1'b0);
		send_text("SPEARS");

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: ;
				1: reconfigure(1'b0, 6'd0);
				2: reconfigure(1'b1, 6'd0);
				3: reconfigure(1'b0, 6'd63);
				4: reconfigure(1'b1, 6'd63);
				default: reconfigure(1'($urandom_range(1)), 6'($urandom_range(63)));
			endcase
			// One phase runs without any idling on either side.
			idle_en <= (p != 2);
			while (bytes_sent < (p + 1) * ITEM_TARGET / PHASES)
				send_message(make_message());
		end

		wait_drained();
		if (fail_count == 0 && verdicts_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
src/kcs_pkg.sv
src/keyword_content_scanner.sv
verif/keyword_content_scanner_checker.sv
verif/keyword_content_scanner_tb.sv
